// ----- hw/rtl/rsqg_pkg.sv -----
`timescale 1ns / 1ps
package rsqg_pkg;

    localparam int MAX_SECTIONS    = 50;
    localparam int SINE_TABLE_BITS = 10;
    localparam int COORD_BITS      = 16;

    localparam int STEPS_MIN   = 3;
    localparam int STEPS_RESET = 16;
    localparam int INC_RESET   = 4096;

    localparam int STEP_W    = 6;
    localparam int INC_W     = 15;
    localparam int PHASE_W   = 16;
    localparam int TRIG_W    = 16;
    localparam int FRAC_BITS = 15;
    localparam int RAD_W     = COORD_BITS - 1;
    localparam int PROD_W    = RAD_W + 1 + TRIG_W;
    localparam int QB        = SINE_TABLE_BITS - 2;
    localparam int QUARTER   = 1 << QB;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = INC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_STEPS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_INCREMENT = CFG_IDX_W'(1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [PROD_W-1:0] SAT_HI =
        PROD_W'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    typedef logic [14:0] qtab_t [0:QUARTER];

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              start;
        logic              issue;
        logic              last;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic advance;
    } stat_t;

    typedef struct packed {
        logic [STEP_W-1:0]            section_index;
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_z;
        logic signed [COORD_BITS-1:0] d_x;
        logic signed [COORD_BITS-1:0] d_z;
        logic signed [COORD_BITS-1:0] low_height;
        logic signed [COORD_BITS-1:0] high_height;
        logic                         last_quad;
    } quad_t;

    // quarter sine wave in Q15, taylor series in Q30, evaluated at elaboration
    function automatic qtab_t build_qtab();
        qtab_t              tab;
        logic [63:0]        theta;
        logic [63:0]        th2;
        logic [63:0]        t;
        logic [63:0]        q;
        logic signed [63:0] sum;
        int                 k;
        for (k = 0; k <= QUARTER; k++)
        begin
            theta = (64'(k) * HALF_PI_Q30) >> QB;
            th2   = (theta * theta) >> 30;
            t     = theta;
            sum   = signed'(theta);
            t = ((t * th2) >> 30) / 64'd6;   sum = sum - signed'(t);
            t = ((t * th2) >> 30) / 64'd20;  sum = sum + signed'(t);
            t = ((t * th2) >> 30) / 64'd42;  sum = sum - signed'(t);
            t = ((t * th2) >> 30) / 64'd72;  sum = sum + signed'(t);
            t = ((t * th2) >> 30) / 64'd110; sum = sum - signed'(t);
            t = ((t * th2) >> 30) / 64'd156; sum = sum + signed'(t);
            t = ((t * th2) >> 30) / 64'd210; sum = sum - signed'(t);
            if (sum < 0)
                sum = 0;
            q = (64'(sum) + (64'd1 << 14)) >> 15;
            if (q > 64'd32767)
                q = 64'd32767;
            tab[k] = 15'(q);
        end
        return tab;
    endfunction

    localparam qtab_t QUARTER_TAB = build_qtab();

    // full wave by mirroring the quarter table
    function automatic logic signed [TRIG_W-1:0] sine_at(logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0]    hq;
        logic [QB-1:0] r;
        logic [QB:0]   ridx;
        logic [14:0]   mag;
        hq   = idx[SINE_TABLE_BITS-1 -: 2];
        r    = idx[QB-1:0];
        ridx = hq[0] ? ((QB+1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
        mag  = QUARTER_TAB[ridx];
        return hq[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

    // floor(p / 2^15), clipped to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] scale_sat(logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        sh = p >>> FRAC_BITS;
        if (sh > SAT_HI)
            sh = SAT_HI;
        else if (sh < SAT_LO)
            sh = SAT_LO;
        return COORD_BITS'(sh);
    endfunction

endpackage

// ----- hw/rtl/rsqg_channels.sv -----
`timescale 1ns / 1ps
interface rsqg_point_if;
    import rsqg_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         profile_end;

    modport source (output valid, point_x, point_y, profile_end, input ready);
    modport sink   (input valid, point_x, point_y, profile_end, output ready);
endinterface

interface rsqg_quad_if;
    import rsqg_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [STEP_W-1:0]            section_index;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_z;
    logic signed [COORD_BITS-1:0] d_x;
    logic signed [COORD_BITS-1:0] d_z;
    logic signed [COORD_BITS-1:0] low_height;
    logic signed [COORD_BITS-1:0] high_height;
    logic                         last_quad;

    modport source (output valid, section_index, a_x, a_z, b_x, b_z, c_x, c_z, d_x, d_z,
                    low_height, high_height, last_quad, input ready);
    modport sink   (input valid, section_index, a_x, a_z, b_x, b_z, c_x, c_z, d_x, d_z,
                    low_height, high_height, last_quad, output ready);
endinterface

interface rsqg_cfg_if;
    import rsqg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rsqg_ctrl.sv -----
`timescale 1ns / 1ps
module rsqg_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      point_valid,
    output logic                      point_ready,
    input  logic                      profile_end,
    input  logic [rsqg_pkg::STEP_W-1:0] rotation_steps,
    output rsqg_pkg::cmd_t            cmd,
    input  rsqg_pkg::stat_t           stat
);
    import rsqg_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              prior_valid_reg, prior_valid_next;
    logic              accept;
    logic              last;

    assign point_ready = (state_reg == ST_IDLE);
    assign accept      = point_valid && point_ready;
    assign last        = (step_reg == rotation_steps - STEP_W'(1));

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        prior_valid_next = prior_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    prior_valid_next = !profile_end;
                    step_next        = '0;
                    if (prior_valid_reg)
                        state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stat.advance)
                begin
                    step_next = step_reg + STEP_W'(1);
                    if (last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            prior_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            prior_valid_reg <= prior_valid_next;
        end
    end

    assign cmd.load  = accept;
    assign cmd.start = accept;
    assign cmd.issue = (state_reg == ST_RUN);
    assign cmd.last  = last;
    assign cmd.step  = step_reg;

endmodule

// ----- hw/rtl/rsqg_dpath.sv -----
`timescale 1ns / 1ps
module rsqg_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rsqg_pkg::cmd_t                      cmd,
    output rsqg_pkg::stat_t                     stat,
    input  logic signed [rsqg_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [rsqg_pkg::COORD_BITS-1:0] point_y,
    input  logic [rsqg_pkg::INC_W-1:0]          angle_increment,
    input  logic                                quad_ready,
    output logic                                quad_valid,
    output rsqg_pkg::quad_t                     quad_data
);
    import rsqg_pkg::*;

    localparam logic [SINE_TABLE_BITS-1:0] QTR_IDX = SINE_TABLE_BITS'(QUARTER);

    logic                         adv;
    logic [RAD_W-1:0]             new_rad;
    logic signed [COORD_BITS-1:0] neg_x;
    logic [PHASE_W-1:0]           ph1;

    // held points
    logic [RAD_W-1:0]             prior_rad_reg, cur_rad_reg;
    logic signed [COORD_BITS-1:0] prior_hgt_reg, cur_hgt_reg;
    logic [PHASE_W-1:0]           phase_reg;

    // stage a: table indexes
    logic                         a_valid_reg;
    logic [STEP_W-1:0]            a_step_reg;
    logic                         a_last_reg;
    logic [SINE_TABLE_BITS-1:0]   a_idx0_reg, a_idx1_reg;
    logic [RAD_W-1:0]             a_rp_reg, a_rc_reg;
    logic signed [COORD_BITS-1:0] a_hp_reg, a_hc_reg;

    // stage b: trig values
    logic                         b_valid_reg;
    logic [STEP_W-1:0]            b_step_reg;
    logic                         b_last_reg;
    logic signed [TRIG_W-1:0]     b_c0_reg, b_s0_reg, b_c1_reg, b_s1_reg;
    logic [RAD_W-1:0]             b_rp_reg, b_rc_reg;
    logic signed [COORD_BITS-1:0] b_hp_reg, b_hc_reg;

    // stage c: products
    logic                         c_valid_reg;
    logic [STEP_W-1:0]            c_step_reg;
    logic                         c_last_reg;
    logic signed [PROD_W-1:0]     c_pc0_reg, c_ps0_reg, c_pc1_reg, c_ps1_reg;
    logic signed [PROD_W-1:0]     c_qc0_reg, c_qs0_reg, c_qc1_reg, c_qs1_reg;
    logic signed [COORD_BITS-1:0] c_hp_reg, c_hc_reg;

    // output stage
    logic                         out_valid_reg;
    quad_t                        out_reg;

    assign adv          = !out_valid_reg || quad_ready;
    assign stat.advance = adv && cmd.issue;
    assign quad_valid   = out_valid_reg;
    assign quad_data    = out_reg;

    // radius is |x|, most negative x clips to the largest radius
    assign neg_x   = -point_x;
    assign new_rad = point_x[COORD_BITS-1] ?
                     (neg_x[COORD_BITS-1] ? {RAD_W{1'b1}} : neg_x[RAD_W-1:0]) :
                     point_x[RAD_W-1:0];

    // angle i+1 wraps to zero on the last section
    assign ph1 = cmd.last ? '0 : phase_reg + PHASE_W'(angle_increment);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prior_rad_reg <= cur_rad_reg;
            prior_hgt_reg <= cur_hgt_reg;
            cur_rad_reg   <= new_rad;
            cur_hgt_reg   <= point_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (cmd.start)
            phase_reg <= '0;
        else if (cmd.issue && adv)
            phase_reg <= ph1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= cmd.issue;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_step_reg <= cmd.step;
            a_last_reg <= cmd.last;
            a_idx0_reg <= phase_reg[PHASE_W-1 -: SINE_TABLE_BITS];
            a_idx1_reg <= ph1[PHASE_W-1 -: SINE_TABLE_BITS];
            a_rp_reg   <= prior_rad_reg;
            a_rc_reg   <= cur_rad_reg;
            a_hp_reg   <= prior_hgt_reg;
            a_hc_reg   <= cur_hgt_reg;

            b_step_reg <= a_step_reg;
            b_last_reg <= a_last_reg;
            b_c0_reg   <= sine_at(a_idx0_reg + QTR_IDX);
            b_s0_reg   <= sine_at(a_idx0_reg);
            b_c1_reg   <= sine_at(a_idx1_reg + QTR_IDX);
            b_s1_reg   <= sine_at(a_idx1_reg);
            b_rp_reg   <= a_rp_reg;
            b_rc_reg   <= a_rc_reg;
            b_hp_reg   <= a_hp_reg;
            b_hc_reg   <= a_hc_reg;

            c_step_reg <= b_step_reg;
            c_last_reg <= b_last_reg;
            c_pc0_reg  <= PROD_W'(signed'({1'b0, b_rp_reg})) * PROD_W'(b_c0_reg);
            c_ps0_reg  <= PROD_W'(signed'({1'b0, b_rp_reg})) * PROD_W'(b_s0_reg);
            c_pc1_reg  <= PROD_W'(signed'({1'b0, b_rp_reg})) * PROD_W'(b_c1_reg);
            c_ps1_reg  <= PROD_W'(signed'({1'b0, b_rp_reg})) * PROD_W'(b_s1_reg);
            c_qc0_reg  <= PROD_W'(signed'({1'b0, b_rc_reg})) * PROD_W'(b_c0_reg);
            c_qs0_reg  <= PROD_W'(signed'({1'b0, b_rc_reg})) * PROD_W'(b_s0_reg);
            c_qc1_reg  <= PROD_W'(signed'({1'b0, b_rc_reg})) * PROD_W'(b_c1_reg);
            c_qs1_reg  <= PROD_W'(signed'({1'b0, b_rc_reg})) * PROD_W'(b_s1_reg);
            c_hp_reg   <= b_hp_reg;
            c_hc_reg   <= b_hc_reg;

            out_reg.section_index <= c_step_reg;
            out_reg.a_x           <= scale_sat(c_pc0_reg);
            out_reg.a_z           <= scale_sat(c_ps0_reg);
            out_reg.b_x           <= scale_sat(c_pc1_reg);
            out_reg.b_z           <= scale_sat(c_ps1_reg);
            out_reg.c_x           <= scale_sat(c_qc1_reg);
            out_reg.c_z           <= scale_sat(c_qs1_reg);
            out_reg.d_x           <= scale_sat(c_qc0_reg);
            out_reg.d_z           <= scale_sat(c_qs0_reg);
            out_reg.low_height    <= c_hp_reg;
            out_reg.high_height   <= c_hc_reg;
            out_reg.last_quad     <= c_last_reg;
        end
    end

endmodule

// ----- hw/rtl/revolution_surface_quad_generator_core.sv -----
`timescale 1ns / 1ps
// surface of revolution quad generator
// point channel: one 2d profile point per transfer (point_x, point_y, profile_end);
//   |point_x| is the radius, point_y the height, profile_end closes the profile
// quad channel: one quad per transfer, joining the previous and current point at
//   angles i and i+1; last_quad marks the final quad of a point
// cfg channel: index 0 writes rotation_steps (clamped to 3..50), index 1 writes
//   angle_increment; write only while no quads are outstanding
// points: a point that opens a profile makes no quad; any other point makes
//   rotation_steps quads, issued by the section sequencer one quad per cycle
//   unless the quad receiver stalls; no point is taken while they issue
// pipeline: after its transfer, the sequencer issues the quads of a point, and each
//   passes through the registered index, table, multiply and output stages
// a stalled quad receiver freezes the whole pipeline and the sequencer's section
//   counter; the next point can be taken while earlier quads still drain
// reset: rotation_steps 16, angle_increment 4096, no prior point held,
//   pipeline empty
module revolution_surface_quad_generator_core (
    input  logic              clk,
    input  logic              rst_n,
    rsqg_point_if.sink        point,
    rsqg_quad_if.source       quad,
    rsqg_cfg_if.sink          cfg
);
    import rsqg_pkg::*;

    logic [STEP_W-1:0] rotation_steps_reg;
    logic [INC_W-1:0]  angle_increment_reg;
    logic [STEP_W-1:0] steps_wr;
    cmd_t              cmd;
    stat_t             stat;
    quad_t             quad_data;

    // configuration is always accepted
    assign cfg.ready = 1'b1;

    // clamp the section count on write
    always_comb
    begin
        steps_wr = cfg.data[STEP_W-1:0];
        if (steps_wr < STEP_W'(STEPS_MIN))
            steps_wr = STEP_W'(STEPS_MIN);
        else if (steps_wr > STEP_W'(MAX_SECTIONS))
            steps_wr = STEP_W'(MAX_SECTIONS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_steps_reg  <= STEP_W'(STEPS_RESET);
            angle_increment_reg <= INC_W'(INC_RESET);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ROTATION_STEPS:  rotation_steps_reg  <= steps_wr;
                CFG_ANGLE_INCREMENT: angle_increment_reg <= cfg.data[INC_W-1:0];
                default:             ;
            endcase
        end
    end

    // sequencer: accepts points, steps the section counter
    rsqg_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .point_valid    (point.valid),
        .point_ready    (point.ready),
        .profile_end    (point.profile_end),
        .rotation_steps (rotation_steps_reg),
        .cmd            (cmd),
        .stat           (stat)
    );

    // datapath: held points, phase, table, products and output register
    rsqg_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .point_x         (point.point_x),
        .point_y         (point.point_y),
        .angle_increment (angle_increment_reg),
        .quad_ready      (quad.ready),
        .quad_valid      (quad.valid),
        .quad_data       (quad_data)
    );

    assign quad.section_index = quad_data.section_index;
    assign quad.a_x           = quad_data.a_x;
    assign quad.a_z           = quad_data.a_z;
    assign quad.b_x           = quad_data.b_x;
    assign quad.b_z           = quad_data.b_z;
    assign quad.c_x           = quad_data.c_x;
    assign quad.c_z           = quad_data.c_z;
    assign quad.d_x           = quad_data.d_x;
    assign quad.d_z           = quad_data.d_z;
    assign quad.low_height    = quad_data.low_height;
    assign quad.high_height   = quad_data.high_height;
    assign quad.last_quad     = quad_data.last_quad;

endmodule

// ----- hw/rtl/rsqg_checker.sv -----
`timescale 1ns / 1ps
module rsqg_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                quad_valid,
    input logic                                quad_ready,
    input logic [rsqg_pkg::STEP_W-1:0]         section_index,
    input logic signed [rsqg_pkg::COORD_BITS-1:0] a_x,
    input logic signed [rsqg_pkg::COORD_BITS-1:0] a_z,
    input logic signed [rsqg_pkg::COORD_BITS-1:0] d_z,
    input logic                                last_quad
);
    import rsqg_pkg::*;

    // a stalled quad stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && !quad_ready |=> quad_valid)
        else $error("quad valid dropped while stalled");

    // a stalled quad keeps its section index, a_x and last_quad
    assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && !quad_ready |=>
            $stable(section_index) && $stable(a_x) && $stable(last_quad))
        else $error("quad payload changed while stalled");

    // at least three sections, so the closing quad is never below section two
    assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && last_quad |-> section_index >= STEP_W'(STEPS_MIN - 1))
        else $error("closing quad at too low a section");

    // angle zero has no z component
    assert property (@(posedge clk) disable iff (!rst_n)
        quad_valid && section_index == '0 |-> a_z == '0 && d_z == '0)
        else $error("nonzero z at section zero");

endmodule

bind revolution_surface_quad_generator_core rsqg_checker u_rsqg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .quad_valid    (quad.valid),
    .quad_ready    (quad.ready),
    .section_index (quad.section_index),
    .a_x           (quad.a_x),
    .a_z           (quad.a_z),
    .d_z           (quad.d_z),
    .last_quad     (quad.last_quad)
);
